[hw/rtl/rsi_pkg.sv]
package rsi_pkg;

  // Number of relay channels kept in the channel store (1 to 16).
  localparam int unsigned CHANNELS = 12;
  localparam int unsigned CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int unsigned MS_W        = 26;     // 65535 s in ms fits 26 bits
  localparam logic [9:0]  MS_PER_S    = 10'd1000;
  localparam logic [31:0] THROTTLE_MS = 32'd5000;

  // Item kinds.
  localparam logic [2:0] KIND_EVAL  = 3'd0;
  localparam logic [2:0] KIND_REC   = 3'd1;
  localparam logic [2:0] KIND_TICK  = 3'd2;
  localparam logic [2:0] KIND_ACK   = 3'd3;
  localparam logic [2:0] KIND_CLEAR = 3'd4;

  // Lockout states.
  localparam logic [2:0] LK_NORMAL  = 3'd0;
  localparam logic [2:0] LK_TRIPPED = 3'd1;
  localparam logic [2:0] LK_ACKED   = 3'd2;
  localparam logic [2:0] LK_CLEARED = 3'd3;
  localparam logic [2:0] LK_ARMED   = 3'd4;

  // Decisions.
  localparam logic [2:0] DEC_ALLOW   = 3'd0;
  localparam logic [2:0] DEC_FORCED  = 3'd1;
  localparam logic [2:0] DEC_MIN_OFF = 3'd2;
  localparam logic [2:0] DEC_MIN_ON  = 3'd3;
  localparam logic [2:0] DEC_CHATTER = 3'd4;

  // Alarm codes.
  localparam logic [2:0] ALM_NONE    = 3'd0;
  localparam logic [2:0] ALM_FORCED  = 3'd1;
  localparam logic [2:0] ALM_MIN_OFF = 3'd2;
  localparam logic [2:0] ALM_MIN_ON  = 3'd3;
  localparam logic [2:0] ALM_CHATTER = 3'd4;
  localparam logic [2:0] ALM_TRIP    = 3'd5;

  // Configuration register indexes.
  localparam logic [1:0] REG_MIN_OFF = 2'd0;
  localparam logic [1:0] REG_MIN_ON  = 2'd1;
  localparam logic [1:0] REG_MIN_SW  = 2'd2;
  localparam logic [1:0] REG_MAX_ON  = 2'd3;

  typedef struct packed {
    logic [31:0] last_change;
    logic [31:0] on_since;
    logic        relay_on;
    logic        forced_off;
    logic        fault;
    logic [2:0]  lockout;
  } chan_t;

  typedef struct packed {
    logic [2:0] decision;
    logic       accepted;
    logic       trip_found;
    logic [3:0] trip_channel;
    logic [2:0] alarm_code;
    logic [2:0] lockout_state;
    logic       lockout_active;
  } res_t;

endpackage

[hw/rtl/rsi_chan_store.sv]
module rsi_chan_store import rsi_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            we_i,
  input  logic [CH_W-1:0] waddr_i,
  input  chan_t           wdata_i,
  input  logic [CH_W-1:0] raddr_i,
  output chan_t           rdata_o
);

  chan_t               mem [CHANNELS];
  logic [CHANNELS-1:0] vld_q;
  chan_t               rdata_q;

  // An entry never written reads as the reset entry, which is all zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (we_i) begin
      vld_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= vld_q[raddr_i] ? mem[raddr_i] : '0;
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/relay_safety_interlock_unit.sv]
// Evaluate, record, acknowledge and clear go through EXEC and OUT to the output register.
// A tick scans the channel store one channel per cycle, twice when nothing trips;
// the one read port of the channel memory sets this pace.
// One word is in work at a time; a finished word waits in the output register.
// Reset (rst_ni low, asynchronous) clears all channel entries, limits and alarm timers.
module relay_safety_interlock_unit import rsi_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  kind_i,
  input  logic [3:0]  channel_i,
  input  logic        desired_on_i,
  input  logic        current_on_i,
  input  logic [31:0] now_ms_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  decision_o,
  output logic        accepted_o,
  output logic        trip_found_o,
  output logic [3:0]  trip_channel_o,
  output logic [2:0]  alarm_code_o,
  output logic [2:0]  lockout_state_o,
  output logic        lockout_active_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  // One-hot sequencer. EXEC handles every kind but tick. SCAN is the trip search,
  // FIX the fault and lockout pass, RPT/RPT2 re-read the addressed channel's lockout.
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_EXEC = 7'b0000010,
    S_SCAN = 7'b0000100,
    S_FIX  = 7'b0001000,
    S_RPT  = 7'b0010000,
    S_RPT2 = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_e;

  localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

  state_e state_q, state_d;

  // Limits are kept in milliseconds so that every rule is one subtract and compare.
  logic [MS_W-1:0] min_off_ms_q, min_on_ms_q, min_sw_ms_q, max_on_ms_q;
  logic [MS_W-1:0] cfg_ms;
  logic [31:0]     thr_q [3];
  logic [31:0]     thr_d [3];

  logic [2:0]      kind_q;
  logic [3:0]      ch_q;
  logic            want_q, cur_q, chv_q;
  logic [31:0]     now_q;
  logic [CH_W-1:0] idx_q, idx_d;
  res_t            res_q, res_d;
  res_t            out_q;
  logic            out_valid_q;

  logic            in_acc, out_free;
  logic            in_chv;
  logic            we;
  logic [CH_W-1:0] waddr, raddr;
  chan_t           wdata, rd;
  logic [CH_W-1:0] idx_next;

  logic [31:0] since_last, since_on;
  logic        trip_hit;
  logic [2:0]  lk_new;

  rsi_chan_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rd)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_chv      = ({1'b0, channel_i} < 5'(CHANNELS));
  assign cfg_ready_o = 1'b1;
  assign cfg_ms      = {{(MS_W-16){1'b0}}, cfg_data_i} * {{(MS_W-10){1'b0}}, MS_PER_S};

  assign idx_next   = (idx_q == LAST_CH) ? '0 : idx_q + CH_W'(1);
  assign since_last = now_q - rd.last_change;
  assign since_on   = now_q - rd.on_since;
  assign trip_hit   = (max_on_ms_q != '0) && rd.relay_on && !rd.forced_off &&
                      (rd.on_since != '0) && (since_on >= {{(32-MS_W){1'b0}}, max_on_ms_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_off_ms_q <= '0;
      min_on_ms_q  <= '0;
      min_sw_ms_q  <= '0;
      max_on_ms_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MIN_OFF: min_off_ms_q <= cfg_ms;
        REG_MIN_ON:  min_on_ms_q  <= cfg_ms;
        REG_MIN_SW:  min_sw_ms_q  <= cfg_ms;
        REG_MAX_ON:  max_on_ms_q  <= cfg_ms;
        default:     ;
      endcase
    end
  end

  // Read address: the channel store is always read; the word arrives in the next cycle.
  always_comb begin
    raddr = '0;
    if (state_q == S_IDLE) begin
      raddr = (kind_i != KIND_TICK && in_chv) ? channel_i[CH_W-1:0] : '0;
    end else if (state_q == S_SCAN || state_q == S_FIX) begin
      raddr = idx_next;
    end else if (state_q == S_RPT) begin
      raddr = chv_q ? ch_q[CH_W-1:0] : '0;
    end
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    res_d   = res_q;
    thr_d   = thr_q;
    we      = 1'b0;
    waddr   = idx_q;
    wdata   = rd;
    lk_new  = rd.lockout;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          idx_d   = '0;
          state_d = (kind_i == KIND_TICK) ? S_SCAN : S_EXEC;
        end
      end

      S_EXEC: begin
        res_d = '0;
        waddr = ch_q[CH_W-1:0];
        if (chv_q) begin
          case (kind_q)
            KIND_EVAL: begin
              if (want_q != cur_q) begin
                if (rd.forced_off && want_q) begin
                  res_d.decision   = DEC_FORCED;
                  res_d.alarm_code = ALM_FORCED;
                end else if (want_q && min_off_ms_q != '0 && rd.last_change != '0 &&
                             since_last < {{(32-MS_W){1'b0}}, min_off_ms_q}) begin
                  res_d.decision = DEC_MIN_OFF;
                  if (now_q - thr_q[0] > THROTTLE_MS) begin
                    thr_d[0]         = now_q;
                    res_d.alarm_code = ALM_MIN_OFF;
                  end
                end else if (!want_q && min_on_ms_q != '0 && rd.on_since != '0 &&
                             since_on < {{(32-MS_W){1'b0}}, min_on_ms_q}) begin
                  res_d.decision = DEC_MIN_ON;
                  if (now_q - thr_q[1] > THROTTLE_MS) begin
                    thr_d[1]         = now_q;
                    res_d.alarm_code = ALM_MIN_ON;
                  end
                end else if (min_sw_ms_q != '0 && rd.last_change != '0 &&
                             since_last < {{(32-MS_W){1'b0}}, min_sw_ms_q}) begin
                  res_d.decision = DEC_CHATTER;
                  if (now_q - thr_q[2] > THROTTLE_MS) begin
                    thr_d[2]         = now_q;
                    res_d.alarm_code = ALM_CHATTER;
                  end
                end
              end
            end
            KIND_REC: begin
              we                = 1'b1;
              wdata.last_change = now_q;
              wdata.on_since    = want_q ? now_q : '0;
              wdata.relay_on    = want_q;
            end
            KIND_ACK: begin
              if (rd.lockout == LK_TRIPPED) begin
                we             = 1'b1;
                wdata.lockout  = LK_ACKED;
                lk_new         = LK_ACKED;
                res_d.accepted = 1'b1;
              end
            end
            KIND_CLEAR: begin
              if (rd.lockout == LK_ACKED && !(rd.fault && rd.relay_on)) begin
                we               = 1'b1;
                wdata.lockout    = LK_CLEARED;
                wdata.fault      = 1'b0;
                wdata.forced_off = 1'b0;
                lk_new           = LK_CLEARED;
                res_d.accepted   = 1'b1;
              end
            end
            default: ;
          endcase
          res_d.lockout_state  = lk_new;
          res_d.lockout_active = (lk_new != LK_NORMAL) && (lk_new != LK_ARMED);
        end
        state_d = S_OUT;
      end

      S_SCAN: begin
        if (trip_hit) begin
          we               = 1'b1;
          wdata.forced_off = 1'b1;
          wdata.fault      = 1'b1;
          wdata.lockout    = LK_TRIPPED;
          res_d              = '0;
          res_d.trip_found   = 1'b1;
          res_d.trip_channel = 4'(idx_q);
          res_d.alarm_code   = ALM_TRIP;
          state_d            = S_RPT;
        end else if (idx_q == LAST_CH) begin
          idx_d   = '0;
          state_d = S_FIX;
        end else begin
          idx_d = idx_next;
        end
      end

      S_FIX: begin
        // No channel tripped: resolve faults of relays that are off, step lockouts.
        we = 1'b1;
        if (rd.fault && !rd.relay_on) begin
          wdata.fault = 1'b0;
        end
        if (rd.lockout == LK_CLEARED) begin
          wdata.lockout = LK_ARMED;
        end else if (rd.lockout == LK_ARMED) begin
          wdata.lockout = LK_NORMAL;
        end
        idx_d = idx_next;
        if (idx_q == LAST_CH) begin
          res_d   = '0;
          state_d = S_RPT;
        end
      end

      S_RPT: begin
        state_d = S_RPT2;
      end

      S_RPT2: begin
        lk_new               = chv_q ? rd.lockout : LK_NORMAL;
        res_d.lockout_state  = lk_new;
        res_d.lockout_active = (lk_new != LK_NORMAL) && (lk_new != LK_ARMED);
        state_d              = S_OUT;
      end

      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      thr_q[0]    <= '0;
      thr_q[1]    <= '0;
      thr_q[2]    <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      thr_q   <= thr_d;
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q <= kind_i;
      ch_q   <= channel_i;
      want_q <= desired_on_i;
      cur_q  <= current_on_i;
      now_q  <= now_ms_i;
      chv_q  <= in_chv;
    end
    res_q <= res_d;
    if (state_q == S_OUT && out_free) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign decision_o       = out_q.decision;
  assign accepted_o       = out_q.accepted;
  assign trip_found_o     = out_q.trip_found;
  assign trip_channel_o   = out_q.trip_channel;
  assign alarm_code_o     = out_q.alarm_code;
  assign lockout_state_o  = out_q.lockout_state;
  assign lockout_active_o = out_q.lockout_active;

endmodule

[test/relay_safety_interlock_unit_tb.sv]
`timescale 1ns / 100ps

module relay_safety_interlock_unit_tb;
  import rsi_pkg::*;

  // Scoreboard: it mirrors the interlock state and keeps a queue of the
  // result words still owed by the block.
  class interlock_sb;
    logic [15:0] min_off_s, min_on_s, min_sw_s, max_on_s;
    logic [31:0] last_change[16];
    logic [31:0] on_since[16];
    logic        relay_on[16];
    logic        forced_off[16];
    logic        fault[16];
    logic [2:0]  lockout[16];
    logic [31:0] throttle_at[3];
    res_t        owed_q[$];
    int          errors;

    function new();
      min_off_s = 0; min_on_s = 0; min_sw_s = 0; max_on_s = 0;
      for (int i = 0; i < 16; i++) begin
        last_change[i] = 0; on_since[i] = 0; relay_on[i] = 0;
        forced_off[i] = 0; fault[i] = 0; lockout[i] = LK_NORMAL;
      end
      for (int i = 0; i < 3; i++) throttle_at[i] = 0;
      errors = 0;
    endfunction

    function void set_limit(logic [1:0] idx, logic [15:0] val);
      case (idx)
        REG_MIN_OFF: min_off_s = val;
        REG_MIN_ON:  min_on_s = val;
        REG_MIN_SW:  min_sw_s = val;
        default:     max_on_s = val;
      endcase
    endfunction

    function bit throttle_open(int slot, logic [31:0] now);
      logic [31:0] d;
      d = now - throttle_at[slot];
      if (d > THROTTLE_MS) begin
        throttle_at[slot] = now;
        return 1;
      end
      return 0;
    endfunction

    function logic [31:0] secs(logic [31:0] now, logic [31:0] t0);
      logic [31:0] d;
      d = now - t0;
      return d / 1000;
    endfunction

    // Notes an accepted word and queues the result it must produce.
    function void note_word(logic [2:0] kind, logic [3:0] ch, logic want, logic cur,
                            logic [31:0] now);
      res_t r;
      bit ok;
      logic [2:0] lk;
      r = '0;
      ok = ch < CHANNELS;
      case (kind)
        KIND_EVAL: if (ok && want != cur) begin
          if (forced_off[ch] && want) begin
            r.decision = DEC_FORCED; r.alarm_code = ALM_FORCED;
          end else if (want && min_off_s != 0 && last_change[ch] != 0 &&
                       secs(now, last_change[ch]) < min_off_s) begin
            r.decision = DEC_MIN_OFF;
            if (throttle_open(0, now)) r.alarm_code = ALM_MIN_OFF;
          end else if (!want && min_on_s != 0 && on_since[ch] != 0 &&
                       secs(now, on_since[ch]) < min_on_s) begin
            r.decision = DEC_MIN_ON;
            if (throttle_open(1, now)) r.alarm_code = ALM_MIN_ON;
          end else if (min_sw_s != 0 && last_change[ch] != 0 &&
                       secs(now, last_change[ch]) < min_sw_s) begin
            r.decision = DEC_CHATTER;
            if (throttle_open(2, now)) r.alarm_code = ALM_CHATTER;
          end
        end
        KIND_REC: if (ok) begin
          last_change[ch] = now;
          on_since[ch] = want ? now : 32'd0;
          relay_on[ch] = want;
        end
        KIND_TICK: begin
          for (int i = 0; i < CHANNELS; i++) begin
            if (max_on_s == 0 || !relay_on[i] || forced_off[i] || on_since[i] == 0)
              continue;
            if (secs(now, on_since[i]) >= max_on_s) begin
              forced_off[i] = 1; lockout[i] = LK_TRIPPED; fault[i] = 1;
              r.trip_found = 1; r.trip_channel = 4'(i); r.alarm_code = ALM_TRIP;
              break;
            end
          end
          if (!r.trip_found) begin
            for (int i = 0; i < CHANNELS; i++) begin
              if (fault[i] && !relay_on[i]) fault[i] = 0;
              if (lockout[i] == LK_CLEARED) lockout[i] = LK_ARMED;
              else if (lockout[i] == LK_ARMED) lockout[i] = LK_NORMAL;
            end
          end
        end
        KIND_ACK: if (ok && lockout[ch] == LK_TRIPPED) begin
          lockout[ch] = LK_ACKED; r.accepted = 1;
        end
        KIND_CLEAR: if (ok && lockout[ch] == LK_ACKED && !(fault[ch] && relay_on[ch])) begin
          lockout[ch] = LK_CLEARED; fault[ch] = 0; forced_off[ch] = 0; r.accepted = 1;
        end
        default: ;
      endcase
      lk = ok ? lockout[ch] : LK_NORMAL;
      r.lockout_state = lk;
      r.lockout_active = (lk != LK_NORMAL && lk != LK_ARMED);
      owed_q.push_back(r);
    endfunction

    function void report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
      errors++;
    endfunction

    // Compares one result word with the oldest owed one.
    function void check_word(res_t got);
      res_t w;
      if (owed_q.size() == 0) begin
        $display("unexpected result word at %0t", $time);
        errors++;
        return;
      end
      w = owed_q.pop_front();
      if (got.decision != w.decision) report("decision", got.decision, w.decision);
      if (got.accepted != w.accepted) report("accepted", got.accepted, w.accepted);
      if (got.trip_found != w.trip_found) report("trip_found", got.trip_found, w.trip_found);
      if (got.trip_channel != w.trip_channel)
        report("trip_channel", got.trip_channel, w.trip_channel);
      if (got.alarm_code != w.alarm_code) report("alarm_code", got.alarm_code, w.alarm_code);
      if (got.lockout_state != w.lockout_state)
        report("lockout_state", got.lockout_state, w.lockout_state);
      if (got.lockout_active != w.lockout_active)
        report("lockout_active", got.lockout_active, w.lockout_active);
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid_i = 0;
  logic        in_stall_o;
  logic [2:0]  kind_i = 0;
  logic [3:0]  channel_i = 0;
  logic        desired_on_i = 0;
  logic        current_on_i = 0;
  logic [31:0] now_ms_i = 0;
  logic        out_valid_o;
  logic        out_stall_i = 0;
  logic [2:0]  decision_o;
  logic        accepted_o;
  logic        trip_found_o;
  logic [3:0]  trip_channel_o;
  logic [2:0]  alarm_code_o;
  logic [2:0]  lockout_state_o;
  logic        lockout_active_o;
  logic        cfg_valid_i = 0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = 0;
  logic [15:0] cfg_data_i = 0;

  relay_safety_interlock_unit u_dut (.*);

  always begin
    #10 clk_i = 1;
    #10 clk_i = 0;
  end

  interlock_sb sb = new();

  // Idle percentages for the sender and the receiver, and the long hold-off.
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  hold_go = 0;
  bit  holding = 0;
  int  cycle_count = 0;
  // The clock a well-formed sequence advances; it wraps past 2^32 on purpose.
  logic [31:0] clock_ms = 32'hFFF0_0001;

  // Long hold-off of the result side, counted here once the main flow asks for it.
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    holding <= 1;
    repeat (300) @(posedge clk_i);
    holding <= 0;
  end

  // Result side: it checks each word on the edge it is taken and picks the
  // stall for the next cycle, held high while the long hold-off runs.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        sb.check_word('{decision_o, accepted_o, trip_found_o, trip_channel_o,
                        alarm_code_o, lockout_state_o, lockout_active_o});
      if (holding) begin
        out_stall_i <= 1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // A generous watchdog; the slowest correct run is far below this.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Offers one word and holds it until the block takes it. Gaps come before
  // the word so that valid never drops between two back-to-back words.
  task automatic send_word(logic [2:0] kind, logic [3:0] ch, logic want, logic cur,
                           logic [31:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1;
    kind_i <= kind;
    channel_i <= ch;
    desired_on_i <= want;
    current_on_i <= cur;
    now_ms_i <= now;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_word(kind, ch, want, cur, now);
  endtask

  // Waits until every owed word has come, plus the longest tick latency.
  task automatic drain();
    in_valid_i <= 0;
    while (sb.owed_q.size() != 0) @(posedge clk_i);
    repeat (2 * CHANNELS + 10) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [1:0] idx, logic [15:0] val);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 0;
    sb.set_limit(idx, val);
  endtask

  task automatic set_limits(logic [15:0] off_s, logic [15:0] on_s, logic [15:0] sw_s,
                            logic [15:0] max_s);
    write_limit(REG_MIN_OFF, off_s);
    write_limit(REG_MIN_ON, on_s);
    write_limit(REG_MIN_SW, sw_s);
    write_limit(REG_MAX_ON, max_s);
  endtask

  // Random word: mostly legal kinds on valid channels with a clock that
  // advances by up to 4000 ms, now and then a wild time stamp or an unused kind.
  task automatic random_word();
    logic [2:0]  kind;
    logic [3:0]  ch;
    logic [31:0] now;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 30) kind = KIND_EVAL;
    else if (pick < 55) kind = KIND_REC;
    else if (pick < 75) kind = KIND_TICK;
    else if (pick < 85) kind = KIND_ACK;
    else if (pick < 95) kind = KIND_CLEAR;
    else kind = 3'($urandom_range(7));
    ch = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(CHANNELS - 1));
    clock_ms = clock_ms + $urandom_range(4000);
    now = ($urandom_range(19) == 0) ? $urandom() : clock_ms;
    send_word(kind, ch, 1'($urandom_range(1)), 1'($urandom_range(1)), now);
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) random_word();
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed part: a trip on channel 0, the operator recovery, the min-on
    // and forced-off refusals, out-of-range channels and unused kinds.
    set_limits(16'd2, 16'd3, 16'd1, 16'd5);
    send_word(KIND_EVAL, 4'd0, 1, 0, 32'd100);
    send_word(KIND_REC, 4'd0, 1, 0, 32'd1000);
    send_word(KIND_EVAL, 4'd0, 0, 1, 32'd2000);
    send_word(KIND_EVAL, 4'd0, 0, 1, 32'd3000);
    send_word(KIND_TICK, 4'd0, 0, 0, 32'd4000);
    send_word(KIND_TICK, 4'd0, 0, 0, 32'd7000);
    send_word(KIND_EVAL, 4'd0, 1, 0, 32'd7100);
    send_word(KIND_CLEAR, 4'd0, 0, 0, 32'd7200);
    send_word(KIND_ACK, 4'd0, 0, 0, 32'd7300);
    send_word(KIND_CLEAR, 4'd0, 0, 0, 32'd7400);
    send_word(KIND_REC, 4'd0, 0, 0, 32'd7500);
    send_word(KIND_EVAL, 4'd0, 1, 0, 32'd8000);
    send_word(KIND_EVAL, 4'd0, 1, 0, 32'd15000);
    send_word(KIND_CLEAR, 4'd0, 0, 0, 32'd15100);
    send_word(KIND_TICK, 4'd0, 0, 0, 32'd16000);
    send_word(KIND_TICK, 4'd0, 0, 0, 32'd17000);
    send_word(KIND_REC, 4'd15, 1, 0, 32'hFFFF_FFFF);
    send_word(KIND_EVAL, 4'd15, 1, 0, 32'hFFFF_FFFF);
    send_word(KIND_ACK, 4'd12, 0, 0, 32'd0);
    send_word(3'd7, 4'd3, 1, 1, 32'hFFFF_FFFF);
    send_word(3'd5, 4'd11, 0, 1, 32'd0);
    drain();

    // Long hold-off on the result side while words keep coming.
    hold_go = 1;
    for (int i = 0; i < 12; i++) random_word();
    drain();

    send_idle_pct = 31; recv_idle_pct = 63;
    set_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    random_phase(150);
    set_limits(16'd3, 16'd4, 16'd2, 16'd8);
    random_phase(200);

    send_idle_pct = 63; recv_idle_pct = 31;
    set_limits(16'd0, 16'd0, 16'd0, 16'd0);
    random_phase(100);
    set_limits(16'd1, 16'd6, 16'd5, 16'd3);
    random_phase(200);

    send_idle_pct = 0; recv_idle_pct = 0;
    set_limits(16'd5, 16'd2, 16'd1, 16'd12);
    random_phase(300);

    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/rsi_pkg.sv
hw/rtl/rsi_chan_store.sv
hw/rtl/relay_safety_interlock_unit.sv
test/relay_safety_interlock_unit_tb.sv
